### src/modular_exponentiation_top_defines.svh
// Assertion macros shared by the modular exponentiation RTL.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define MODEXP_ASSERT(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("modexp check failed");

// When pre holds, post must hold at the next clock edge.
`define MODEXP_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("modexp sequence check failed");

`endif

### src/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
// No dependencies; used by modexp_mulmod and modular_exponentiation_top.
`default_nettype none

package modexp_pkg;

    localparam int OPERAND_BITS_DEF = 31;

    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

endpackage

`default_nettype wire

### src/modular_exponentiation_top.sv
// Top level of the modular exponentiation block: stream ports, modulus register, sequencer.
// Depends on modexp_pkg, modexp_mulmod and modular_exponentiation_top_defines.svh.
// Each request carries a base and an exponent and yields base^exponent mod modulus. The base is
// first reduced one bit per cycle (N = OPERAND_BITS); then each of the N exponent bits costs one
// squaring and, when the bit is set, one multiplication, each done by the bit-serial modular
// multiplier. One request is in work at a time; a finished result waits in the output register
// while the next request is accepted. A modulus of zero yields zero. The modulus is written
// through the cfg channel between requests.
`default_nettype none
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // s_tdata fields from bit 0 up: base, exponent
    input  wire logic [((2*OPERAND_BITS+7)/8)*8-1:0]    s_tdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // m_tdata fields from bit 0 up: power_mod
    output logic      [((OPERAND_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    input  wire logic [OPERAND_BITS-1:0]                cfg_data,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready
);

    localparam int CW = $clog2(OPERAND_BITS + 1);
    localparam int OW = ((OPERAND_BITS + 7) / 8) * 8;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_REDUCE   = 3'd1;
    localparam logic [2:0] ST_NEXT     = 3'd2;
    localparam logic [2:0] ST_WAIT_MUL = 3'd3;
    localparam logic [2:0] ST_WAIT_SQR = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [OPERAND_BITS-1:0] mod_reg, mod_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OPERAND_BITS-1:0] out_reg, out_next;
    logic [OPERAND_BITS-1:0] base_sr_reg, base_sr_next;
    logic [OPERAND_BITS-1:0] exp_reg, exp_next;
    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [OPERAND_BITS-1:0] sq_reg, sq_next;

    logic [OPERAND_BITS:0]   shifted;
    logic [OPERAND_BITS:0]   shifted_red;
    logic                    mm_start;
    logic [OPERAND_BITS-1:0] mm_a;
    logic [OPERAND_BITS-1:0] mm_product;
    modexp_pkg::mm_status_t  mm_stat;

    assign shifted     = {sq_reg, base_sr_reg[OPERAND_BITS-1]};
    assign shifted_red = (shifted >= {1'b0, mod_reg}) ? (shifted - {1'b0, mod_reg}) : shifted;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OW'(out_reg);
    assign mm_a      = (state_reg == ST_NEXT && exp_reg[0]) ? acc_reg : sq_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        mod_next       = mod_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        base_sr_next   = base_sr_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        mm_start       = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
            mod_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    base_sr_next = s_tdata[OPERAND_BITS-1:0];
                    exp_next     = s_tdata[2*OPERAND_BITS-1:OPERAND_BITS];
                    sq_next      = '0;
                    cnt_next     = CW'(OPERAND_BITS);
                    state_next   = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                sq_next      = shifted_red[OPERAND_BITS-1:0];
                base_sr_next = base_sr_reg << 1;
                cnt_next     = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    acc_next   = OPERAND_BITS'(mod_reg != OPERAND_BITS'(1));
                    cnt_next   = CW'(OPERAND_BITS);
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    mm_start   = 1'b1;
                    state_next = exp_reg[0] ? ST_WAIT_MUL : ST_WAIT_SQR;
                end
            end
            ST_WAIT_MUL: begin
                if (mm_stat.done) begin
                    acc_next   = mm_product;
                    mm_start   = 1'b1;
                    state_next = ST_WAIT_SQR;
                end
            end
            ST_WAIT_SQR: begin
                if (mm_stat.done) begin
                    sq_next    = mm_product;
                    exp_next   = exp_reg >> 1;
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_NEXT;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_next       = (mod_reg == '0) ? '0 : acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mod_reg       <= OPERAND_BITS'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            mod_reg       <= mod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg     <= out_next;
        base_sr_reg <= base_sr_next;
        exp_reg     <= exp_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
    end

    modexp_mulmod #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .a       (mm_a),
        .b       (sq_reg),
        .m       (mod_reg),
        .stat    (mm_stat),
        .product (mm_product)
    );

    `MODEXP_ASSERT(a_start_when_free, !(mm_start && mm_stat.busy))
    `MODEXP_ASSERT_NEXT(a_accept_reduce, s_tvalid && s_tready, state_reg == ST_REDUCE)
    `MODEXP_ASSERT(a_done_in_wait, !mm_stat.done || state_reg == ST_WAIT_MUL || state_reg == ST_WAIT_SQR)

endmodule

`default_nettype wire

### src/modexp_mulmod.sv
// Bit-serial modular multiplier: product = a * b mod m, one multiplier bit per cycle.
// Depends on modexp_pkg and modular_exponentiation_top_defines.svh.
`default_nettype none
`include "modular_exponentiation_top_defines.svh"

module modexp_mulmod #(
    parameter int OPERAND_BITS = modexp_pkg::OPERAND_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [OPERAND_BITS-1:0]   a,
    input  wire logic [OPERAND_BITS-1:0]   b,
    input  wire logic [OPERAND_BITS-1:0]   m,
    output modexp_pkg::mm_status_t         stat,
    output logic      [OPERAND_BITS-1:0]   product
);

    localparam int CW = $clog2(OPERAND_BITS + 1);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [OPERAND_BITS-1:0] acc_reg, acc_next;
    logic [OPERAND_BITS-1:0] addend_reg, addend_next;
    logic [OPERAND_BITS-1:0] mult_reg, mult_next;

    logic [OPERAND_BITS:0]   m_ext;
    logic [OPERAND_BITS:0]   sum;
    logic [OPERAND_BITS:0]   sum_red;
    logic [OPERAND_BITS:0]   dbl;
    logic [OPERAND_BITS:0]   dbl_red;

    assign m_ext   = {1'b0, m};
    assign sum     = {1'b0, acc_reg} + {1'b0, addend_reg};
    assign sum_red = (sum >= m_ext) ? (sum - m_ext) : sum;
    assign dbl     = {addend_reg, 1'b0};
    assign dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;

    always_comb begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mult_next   = mult_reg;
        if (start) begin
            busy_next   = 1'b1;
            cnt_next    = CW'(OPERAND_BITS);
            acc_next    = '0;
            addend_next = a;
            mult_next   = b;
        end else if (busy_reg) begin
            if (mult_reg[0]) begin
                acc_next = sum_red[OPERAND_BITS-1:0];
            end
            addend_next = dbl_red[OPERAND_BITS-1:0];
            mult_next   = mult_reg >> 1;
            cnt_next    = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mult_reg   <= mult_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

    `MODEXP_ASSERT(a_done_not_busy, !(done_reg && busy_reg))
    `MODEXP_ASSERT_NEXT(a_start_busy, start, busy_reg && cnt_reg == CW'(OPERAND_BITS))
    `MODEXP_ASSERT(a_acc_reduced, !(busy_reg && m != '0 && acc_reg >= m))

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench for modular_exponentiation_top: random and directed base/exponent
// requests under several moduli, each result checked against a square-and-multiply predictor.
// Depends on modexp_pkg and the modular_exponentiation_top RTL.
module tb_top;

    localparam int OPW        = modexp_pkg::OPERAND_BITS_DEF;
    localparam int S_W        = ((2*OPW+7)/8)*8;
    localparam int M_W        = ((OPW+7)/8)*8;
    localparam int IDLE_LIMIT = 20000;
    localparam int END_HOLD   = 2500;
    localparam int PRINT_CAP  = 100;

    localparam logic [OPW-1:0] OPND_MAX = {OPW{1'b1}};

    typedef struct {
        logic [OPW-1:0] base;
        logic [OPW-1:0] exponent;
    } expmod_req_t;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic [S_W-1:0]  s_tdata   = '0;
    logic            s_tvalid  = 1'b0;
    logic            s_tready;
    logic [M_W-1:0]  m_tdata;
    logic            m_tvalid;
    logic            m_tready  = 1'b0;
    logic [OPW-1:0]  cfg_data  = '0;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;

    expmod_req_t     pending_requests[$];
    logic [OPW-1:0]  expected_powers[$];
    logic [OPW-1:0]  active_modulus = OPW'(1);
    int              fail_count     = 0;
    int              modulus_writes = 0;
    int              idle_cycles    = 0;
    int              send_wait      = 0;
    int              send_burst     = 0;
    int              recv_wait      = 0;
    int              recv_burst     = 0;
    bit              s_took         = 1'b0;
    bit              m_took         = 1'b0;

    modular_exponentiation_top #(
        .OPERAND_BITS(OPW)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [OPW-1:0] expmod_predict(input logic [OPW-1:0] b,
                                                      input logic [OPW-1:0] e,
                                                      input logic [OPW-1:0] m);
        logic [63:0] acc;
        logic [63:0] square;
        logic [63:0] m64;
        int          i;
        if (m == 0) begin
            return '0;
        end
        m64    = 64'(m);
        acc    = 64'd1 % m64;
        square = 64'(b) % m64;
        for (i = 0; i < OPW; i++) begin
            if (e[i]) begin
                acc = (acc * square) % m64;
            end
            square = (square * square) % m64;
        end
        return acc[OPW-1:0];
    endfunction

    function automatic int draw_wait(ref int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst_left = $urandom_range(8, 20);
        end
        return $urandom_range(0, 8);
    endfunction

    task automatic report_mismatch(input string what, input logic [OPW-1:0] got,
                                   input logic [OPW-1:0] want);
        fail_count++;
        if (fail_count <= PRINT_CAP) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        end
    endtask

    always @(posedge aclk) begin : monitor
        logic [OPW-1:0] want;
        s_took = aresetn && s_tvalid && s_tready;
        m_took = aresetn && m_tvalid && m_tready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                active_modulus = cfg_data;
                modulus_writes++;
            end
            if (s_took) begin
                expected_powers.push_back(expmod_predict(s_tdata[OPW-1:0],
                                                         s_tdata[2*OPW-1:OPW],
                                                         active_modulus));
            end
            if (m_took) begin
                if (expected_powers.size() == 0) begin
                    report_mismatch("unexpected power_mod", m_tdata[OPW-1:0], '0);
                end else begin
                    want = expected_powers.pop_front();
                    if (m_tdata[OPW-1:0] !== want) begin
                        report_mismatch("power_mod", m_tdata[OPW-1:0], want);
                    end
                end
            end
            if (s_took || m_took || (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(negedge aclk) begin : request_source
        logic        valid_next;
        expmod_req_t req;
        if (aresetn) begin
            valid_next = s_tvalid && !s_took;
            if (!valid_next) begin
                if (send_wait > 0) begin
                    send_wait--;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    s_tdata <= {{(S_W-2*OPW){1'b0}}, req.exponent, req.base};
                    valid_next = 1'b1;
                    send_wait = draw_wait(send_burst);
                end
            end
            s_tvalid <= valid_next;
        end
    end

    always @(negedge aclk) begin : result_sink
        if (aresetn) begin
            if (m_took) begin
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                recv_wait--;
            end
        end
    end

    task automatic push_request(input logic [OPW-1:0] b, input logic [OPW-1:0] e);
        expmod_req_t req;
        req.base     = b;
        req.exponent = e;
        pending_requests.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || s_tvalid || expected_powers.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_modulus(input logic [OPW-1:0] value);
        int start;
        wait_drained();
        start = modulus_writes;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        while (modulus_writes == start) begin
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_random(input logic [OPW-1:0] m, input int count);
        logic [OPW-1:0] b;
        logic [OPW-1:0] e;
        int             n;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: e = OPW'($urandom());
                5, 6:          e = OPW'($urandom_range(0, 40));
                7:             e = OPND_MAX ^ OPW'($urandom() & $urandom());
                8:             e = OPW'($urandom() >> $urandom_range(1, 31));
                default:       e = OPW'($urandom_range(0, 1));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: b = OPW'($urandom());
                6:                b = OPW'($urandom_range(0, 3));
                7:                b = OPW'(m + $urandom_range(0, 2) - 1);
                8:                b = OPND_MAX;
                default:          b = (m > 1) ? OPW'($urandom_range(0, m - 1))
                                              : OPW'($urandom());
            endcase
            push_request(b, e);
        end
    endtask

    initial begin : stimulus
        logic [OPW-1:0] m;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        push_request('0, '0);
        push_request(OPND_MAX, OPND_MAX);
        push_request(31'd5, '0);
        push_request(31'd7, 31'd3);

        set_modulus(OPND_MAX);
        push_request('0, '0);
        push_request('0, 31'd1);
        push_request('0, OPND_MAX);
        push_request(OPND_MAX, '0);
        push_request(OPND_MAX, OPND_MAX);
        push_request(31'd1, OPND_MAX);
        push_request(31'd2, 31'd30);
        push_request(31'd2, 31'd31);
        push_request(31'd2, OPND_MAX);
        push_request(OPND_MAX - 1, 31'd2);
        push_request(OPND_MAX - 1, OPND_MAX);
        push_request(31'd3, 31'h5555_5555);
        push_request(31'h2AAA_AAAA, 31'h2AAA_AAAA);
        push_request(31'd12345, 31'h4000_0000);
        push_request(31'h4000_0000, 31'd1);
        push_request(31'd16807, 31'd2);
        add_random(OPND_MAX, 40);

        set_modulus(31'd1);
        push_request(31'd9, '0);
        add_random(31'd1, 15);

        set_modulus('0);
        push_request('0, '0);
        push_request(OPND_MAX, 31'd3);
        add_random('0, 15);

        set_modulus(31'd2);
        add_random(31'd2, 25);

        set_modulus(31'd3);
        add_random(31'd3, 25);

        m = OPW'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000) | 32'd1);
        set_modulus(m);
        add_random(m, 40);

        m = OPW'($urandom_range(32'h7FFF_FFFF, 32'h4000_0000) & ~32'd1);
        set_modulus(m);
        add_random(m, 30);

        set_modulus(31'd65537);
        add_random(31'd65537, 25);

        m = OPW'($urandom_range(2, 255));
        set_modulus(m);
        add_random(m, 30);

        set_modulus(OPND_MAX - 1);
        add_random(OPND_MAX - 1, 20);

        wait_drained();
        repeat (END_HOLD) @(posedge aclk);
        while (expected_powers.size() != 0) begin
            report_mismatch("missing power_mod", '0, expected_powers.pop_front());
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
